@@ rtl/column_melt_wipe_sequencer_top_defines.svh @@
// assertion macros shared by the column melt wipe sequencer modules
`ifndef COLUMN_MELT_WIPE_SEQUENCER_TOP_DEFINES_SVH
`define COLUMN_MELT_WIPE_SEQUENCER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define CMW_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// checked on every edge, reset included
`define CMW_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define CMW_ASSERT(name, prop, msg)
`define CMW_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ rtl/cmw_pkg.sv @@
package cmw_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = 8;
    localparam int CFG_W   = 9;
    localparam int OFS_W   = 10;
    localparam int TICK_W  = 4;
    localparam int START_W = 5;
    localparam int IDX_W   = 2;

    localparam int FAST_LIMIT = 16;
    localparam int SLOW_STEP  = 8;
    localparam int MIN_START  = -15;

    localparam logic [CFG_W-1:0] ROWS_RESET = 9'd200;
    localparam logic [CFG_W-1:0] COLS_RESET = 9'd160;

    localparam logic [IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [IDX_W-1:0] REG_COLS = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic item_take;
        logic col_read;
        logic col_write;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic tick_empty;
        logic last_col;
        logic last_tick;
        logic out_free;
    } status_t;

endpackage

@@ rtl/cmw_ctrl.sv @@
`include "column_melt_wipe_sequencer_top_defines.svh"

module cmw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [1:0]       s_tuser,
    output logic             s_tready,
    output cmw_pkg::cmd_t    cmd,
    input  cmw_pkg::status_t status
);
    import cmw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_TICK_RD = 4'b0010,
        ST_TICK_WR = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.item_take = 1'b1;
                    if (op_t'(s_tuser) == OP_TICK && !status.tick_empty) begin
                        state_next = ST_TICK_RD;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_TICK_RD: begin
                cmd.col_read = 1'b1;
                state_next   = ST_TICK_WR;
            end
            ST_TICK_WR: begin
                cmd.col_write = 1'b1;
                if (status.last_col && status.last_tick) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_TICK_RD;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CMW_ASSERT(a_take_leaves_idle,
        cmd.item_take |=> (state_reg == ST_FINISH || state_reg == ST_TICK_RD),
        "accepted item did not start work")
    `CMW_ASSERT(a_sweep_continues,
        (cmd.col_write && !(status.last_col && status.last_tick)) |=> cmd.col_read,
        "column sweep stopped early")
    `CMW_ASSERT(a_result_back_idle,
        cmd.result_load |=> s_tready,
        "no return to idle after result")
    `CMW_ASSERT_ALWAYS(a_no_take_in_sweep,
        !(s_tready && (cmd.col_read || cmd.col_write)),
        "item taken during column sweep")

endmodule

@@ rtl/cmw_datapath.sv @@
`include "column_melt_wipe_sequencer_top_defines.svh"

module cmw_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [31:0]                   s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cmw_pkg::IDX_W-1:0]     cfg_index,
    input  logic [cmw_pkg::CFG_W-1:0]     cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,
    input  cmw_pkg::cmd_t                 cmd,
    output cmw_pkg::status_t              status
);
    import cmw_pkg::*;

    logic [COL_W-1:0]          in_col;
    logic [ROW_W-1:0]          in_row;
    logic signed [START_W-1:0] in_start;
    logic [TICK_W-1:0]         in_ticks;

    logic [CFG_W-1:0]  rows_reg, cols_reg;
    logic [CFG_W-1:0]  rows_eff, cols_eff;

    op_t               op_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_cnt_reg;
    logic [TICK_W-1:0] tick_cnt_reg;
    logic              moved_reg;

    logic [OFS_W-1:0]  mem [MAX_COLUMNS];
    logic [OFS_W-1:0]  rd_data_reg;
    logic              mem_we, mem_re;
    logic [COL_W-1:0]  mem_wa, mem_ra;
    logic [OFS_W-1:0]  mem_wd;

    logic [OFS_W-1:0]  load_val;
    logic              y_neg, y_below, y_fast;
    logic [CFG_W-1:0]  y_mag;
    logic [OFS_W-1:0]  dy, y_sum, tick_val;
    logic              col_moved;

    logic              q_pos, q_end;
    logic [ROW_W-1:0]  q_row;
    logic [9:0]        result;

    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;

    assign in_col   = s_tdata[7:0];
    assign in_row   = s_tdata[15:8];
    assign in_start = s_tdata[20:16];
    assign in_ticks = s_tdata[24:21];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_ROWS) begin
                rows_reg <= cfg_data;
            end else if (cfg_index == REG_COLS) begin
                cols_reg <= cfg_data;
            end
        end
    end

    assign rows_eff = (rows_reg > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_reg;
    assign cols_eff = (cols_reg > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cols_reg;

    // load offset clamped to MIN_START..0
    always_comb begin
        if (!in_start[START_W-1] && in_start != '0) begin
            load_val = '0;
        end else if (in_start < START_W'(MIN_START)) begin
            load_val = OFS_W'(MIN_START);
        end else begin
            load_val = {{(OFS_W-START_W){in_start[START_W-1]}}, in_start};
        end
    end

    // one melt step of the column just read
    assign y_neg   = rd_data_reg[OFS_W-1];
    assign y_mag   = rd_data_reg[CFG_W-1:0];
    assign y_below = !y_neg && (y_mag < rows_eff);
    assign y_fast  = y_mag < CFG_W'(FAST_LIMIT);
    assign dy      = y_fast ? ({1'b0, y_mag} + OFS_W'(1)) : OFS_W'(SLOW_STEP);
    assign y_sum   = {1'b0, y_mag} + dy;
    assign col_moved = y_neg || y_below;

    always_comb begin
        if (y_neg) begin
            tick_val = rd_data_reg + OFS_W'(1);
        end else if (y_sum >= {1'b0, rows_eff}) begin
            tick_val = {1'b0, rows_eff};
        end else begin
            tick_val = y_sum;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = in_col;
        mem_wd = load_val;
        mem_re = 1'b0;
        mem_ra = in_col;
        if (cmd.item_take) begin
            mem_we = op_t'(s_tuser) == OP_LOAD;
            mem_re = op_t'(s_tuser) == OP_QUERY;
        end else if (cmd.col_read) begin
            mem_re = 1'b1;
            mem_ra = col_cnt_reg;
        end else if (cmd.col_write) begin
            mem_we = col_moved;
            mem_wa = col_cnt_reg;
            mem_wd = tick_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_take) begin
            op_reg <= op_t'(s_tuser);
            row_reg <= in_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            tick_cnt_reg <= '0;
            moved_reg    <= 1'b0;
        end else if (cmd.item_take) begin
            col_cnt_reg  <= '0;
            tick_cnt_reg <= in_ticks;
            moved_reg    <= 1'b0;
        end else if (cmd.col_write) begin
            moved_reg <= moved_reg | col_moved;
            if (status.last_col) begin
                col_cnt_reg  <= '0;
                tick_cnt_reg <= tick_cnt_reg - TICK_W'(1);
            end else begin
                col_cnt_reg <= col_cnt_reg + COL_W'(1);
            end
        end
    end

    assign status.tick_empty = (in_ticks == '0) || (cols_eff == '0);
    assign status.last_col   = ({1'b0, col_cnt_reg} == cols_eff - CFG_W'(1));
    assign status.last_tick  = (tick_cnt_reg == TICK_W'(1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    // query: rows above the offset show the end frame
    assign q_pos = !rd_data_reg[OFS_W-1] && (rd_data_reg != '0);
    assign q_end = q_pos && ({1'b0, row_reg} < y_mag);
    assign q_row = (q_pos && !q_end) ? row_reg - rd_data_reg[ROW_W-1:0] : row_reg;

    always_comb begin
        case (op_reg)
            OP_TICK:  result = {!moved_reg, 8'd0, 1'b0};
            OP_QUERY: result = {1'b0, q_row, q_end};
            default:  result = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_tdata_reg <= {6'd0, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CMW_ASSERT(a_result_shown,
        cmd.result_load |=> m_tvalid_reg,
        "result register not filled")
    `CMW_ASSERT(a_sweep_in_range,
        cmd.col_write |-> ({1'b0, col_cnt_reg} < cols_eff),
        "column counter past columns in use")
    `CMW_ASSERT(a_pass_wraps,
        (cmd.col_write && status.last_col) |=> (col_cnt_reg == '0),
        "column counter did not wrap after a pass")

endmodule

@@ rtl/column_melt_wipe_sequencer_top.sv @@
// column melt screen-wipe sequencer
// s_ channel: one item per handshake, s_tuser[1:0] holds the opcode
//   (load column offset, advance ticks, query pixel source).
// m_ channel: exactly one result item per input item.
// cfg_ channel: register writes (index 0 rows in use, 1 columns in use),
//   always ready; write only while no item is in flight.
// load, query and unused opcodes pass from idle through the finish state back to idle.
// a tick item walks the offset memory with a read state and a write state per
//   column, for tick_count passes over the columns in use; with zero ticks or zero
//   columns in use it goes straight to the finish state like the other opcodes.
// the result item is loaded into the output register from the finish state (ticks add the walk).
// results leave through an output register; while it holds an unread item the
//   block still accepts the next one and finishes its work, then waits until
//   the register drains before loading the new result.
// reset sets rows in use to 200 and columns in use to 160 and empties the
//   output register; offsets are undefined until each column is loaded.
module column_melt_wipe_sequencer_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // column_index[7:0], row_index[15:8], start_offset[20:16], tick_count[24:21]
    input  logic [31:0]               s_tdata,
    // opcode[1:0]
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // source_is_end[0], source_row[8:1], wipe_done[9]
    output logic [15:0]               m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cmw_pkg::IDX_W-1:0] cfg_index,
    input  logic [cmw_pkg::CFG_W-1:0] cfg_data
);
    import cmw_pkg::*;

    cmd_t    cmd;
    status_t status;

    cmw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    cmw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
